>>> rtl/rspb_pkg.sv
// Package for the RGB565 sprite pixel blender: payload structs, codes,
// palette sizing and register reset values. No dependencies.
`timescale 1ns / 1ps

package rspb_pkg;

  // Palette sizing
  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned SLOT_CMP_W = SLOT_W + 1;

  // Configuration register reset values
  localparam logic [15:0] MODULATE_RESET  = 16'hFFFF;
  localparam logic [15:0] HALF_MASK_RESET = 16'hF7DE;

  typedef enum logic {
    REG_MODULATE_COLOR = 1'b0,
    REG_HALF_MASK      = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_OPAQUE = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_AVG    = 2'd2
  } blend_mode_e;

  // One input transaction
  typedef struct packed {
    logic        action;
    logic [1:0]  blend_mode;
    logic        skip_zero;
    logic        indexed;
    logic [15:0] src_value;
    logic [15:0] dest_pixel;
    logic [7:0]  palette_slot;
    logic [15:0] palette_color;
  } rspb_in_t;

  // One result transaction
  typedef struct packed {
    logic [15:0] out_pixel;
    logic        write_enable;
  } rspb_out_t;

  // Resolved source handed from the fetch stage to the blend pipeline
  typedef struct packed {
    logic        draw;
    logic        skip_hit;
    logic [1:0]  mode;
    logic [15:0] color;
    logic [15:0] dest;
  } rspb_src_t;

endpackage

>>> rtl/rgb565_sprite_pixel_blend_top.sv
// Top level of the RGB565 sprite pixel blender: input stage, palette and
// blend pipeline. Depends on rspb_pkg, rspb_palette and rspb_blend.
`timescale 1ns / 1ps

// Usage
//   Input: drive item_i and raise start for one cycle per transaction. A
//   transaction is taken at each rising edge with start high and busy low;
//   busy is always low, so one transaction can enter every clock.
//   A transaction either writes a palette entry (action = 1) or draws one
//   pixel against the destination value it carries.
//   Output: every transaction yields exactly one result on result_o, shown
//   for one cycle with done_o high. The receiver cannot hold results off.
//   Throughput: 1 per clock.
//   The three register stages are: input/palette read, channel modulation
//   (three narrow multipliers), blend and output register.
//   A palette write is visible to a draw taken at the very next edge.
//   Configuration: cfg_we_i with cfg_idx_i / cfg_wdata_i writes the
//   modulation color (index 0) or average mask (index 1); write only
//   while no transaction is in flight.
//   Reset: rst_ni clears the pipeline valids and loads register defaults.
//   Palette contents are undefined until written.
module rgb565_sprite_pixel_blend_top
  import rspb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  rspb_in_t    item_i,
  output logic        done_o,
  output rspb_out_t   result_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic accept;

  // The pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers
  logic [15:0] modulate_q, half_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulate_q  <= MODULATE_RESET;
      half_mask_q <= HALF_MASK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MODULATE_COLOR: modulate_q  <= cfg_wdata_i;
        REG_HALF_MASK:      half_mask_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Palette: write and lookup both happen at the accept edge
  logic        slot_ok, idx_ok, pal_we;
  logic [15:0] pal_rdata;

  assign slot_ok = SLOT_CMP_W'(item_i.palette_slot) < SLOT_CMP_W'(PAL_DEPTH);
  assign idx_ok  = SLOT_CMP_W'(item_i.src_value[7:0]) < SLOT_CMP_W'(PAL_DEPTH);
  assign pal_we  = accept && item_i.action && slot_ok;

  rspb_palette u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (item_i.palette_slot[PAL_AW-1:0]),
    .wdata_i (item_i.palette_color),
    .raddr_i (item_i.src_value[PAL_AW-1:0]),
    .rdata_o (pal_rdata)
  );

  // Stage 1: hold the transaction while the palette read completes
  logic        s1_valid_q;
  logic        s1_draw_q, s1_indexed_q, s1_skip_q, s1_idx_ok_q;
  logic [1:0]  s1_mode_q;
  logic [15:0] s1_src_q, s1_dest_q;
  rspb_src_t   s1_src;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_draw_q    <= !item_i.action;
    s1_indexed_q <= item_i.indexed;
    s1_skip_q    <= item_i.skip_zero && (item_i.indexed ? (item_i.src_value[7:0] == 8'd0)
                                                        : (item_i.src_value == 16'd0));
    s1_idx_ok_q  <= idx_ok;
    s1_mode_q    <= item_i.blend_mode;
    s1_src_q     <= item_i.src_value;
    s1_dest_q    <= item_i.dest_pixel;
  end

  // Resolve the source color; an out-of-range index reads as zero
  always_comb begin
    s1_src.draw     = s1_draw_q;
    s1_src.skip_hit = s1_skip_q;
    s1_src.mode     = s1_mode_q;
    s1_src.dest     = s1_dest_q;
    if (s1_indexed_q) begin
      s1_src.color = s1_idx_ok_q ? pal_rdata : 16'd0;
    end else begin
      s1_src.color = s1_src_q;
    end
  end

  // Stages 2 and 3: modulate, then blend into the output register
  rspb_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid_q),
    .src_i       (s1_src),
    .modulate_i  (modulate_q),
    .half_mask_i (half_mask_q),
    .valid_o     (done_o),
    .result_o    (result_o)
  );

`ifndef ASSERT_OFF
  // done_o is raised for every accepted transaction and at no other time
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(accept && rst_ni, 3))
    else $error("result strobe does not match accept three cycles earlier");

  // A palette write returns an all-zero result
  a_pal_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni && accept && item_i.action, 3) |-> (result_o == '0))
    else $error("palette write produced a nonzero result");

  // A skipped zero source passes the destination through without a write
  a_skip_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni && accept && !item_i.action && item_i.skip_zero &&
          item_i.src_value == 16'd0, 3)
    |-> (!result_o.write_enable && result_o.out_pixel == $past(item_i.dest_pixel, 3)))
    else $error("skipped source did not pass destination through");

  // A draw that is not skipped always requests a destination write
  a_draw_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni && accept && !item_i.action && !item_i.skip_zero, 3)
    |-> result_o.write_enable)
    else $error("unskipped draw lost its write enable");
`endif

endmodule

>>> rtl/rspb_palette.sv
// Palette memory for the sprite blender: one write port, one registered
// read port. Depends on rspb_pkg.
`timescale 1ns / 1ps

module rspb_palette
  import rspb_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [PAL_AW-1:0] waddr_i,
  input  logic [15:0]       wdata_i,
  input  logic [PAL_AW-1:0] raddr_i,
  output logic [15:0]       rdata_o
);

  logic [15:0] mem_q [PAL_DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rspb_blend.sv
// Two-stage blend pipeline: channel modulation, then opaque / saturating
// add / masked average. Depends on rspb_pkg.
`timescale 1ns / 1ps

module rspb_blend
  import rspb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  rspb_src_t   src_i,
  input  logic [15:0] modulate_i,
  input  logic [15:0] half_mask_i,
  output logic        valid_o,
  output rspb_out_t   result_o
);

  // Modulate stage
  logic [9:0]  prod_r, prod_b;
  logic [11:0] prod_g;

  logic        mod_valid_q;
  logic        mod_draw_q, mod_skip_q;
  logic [1:0]  mod_mode_q;
  logic [15:0] mod_color_q, mod_dest_q;

  assign prod_r = 10'(src_i.color[15:11]) * 10'(modulate_i[15:11]);
  assign prod_g = 12'(src_i.color[10:5])  * 12'(modulate_i[10:5]);
  assign prod_b = 10'(src_i.color[4:0])   * 10'(modulate_i[4:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_valid_q <= 1'b0;
    end else begin
      mod_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_draw_q  <= src_i.draw;
    mod_skip_q  <= src_i.skip_hit;
    mod_mode_q  <= src_i.mode;
    mod_dest_q  <= src_i.dest;
    mod_color_q <= {prod_r[9:5], prod_g[11:6], prod_b[9:5]};
  end

  // Blend stage
  logic [5:0]  sum_r, sum_b;
  logic [6:0]  sum_g;
  logic [15:0] add_px;
  logic [16:0] avg_sum;
  rspb_out_t   res_d, res_q;
  logic        res_valid_q;

  always_comb begin
    sum_r  = 6'(mod_dest_q[15:11]) + 6'(mod_color_q[15:11]);
    sum_g  = 7'(mod_dest_q[10:5])  + 7'(mod_color_q[10:5]);
    sum_b  = 6'(mod_dest_q[4:0])   + 6'(mod_color_q[4:0]);
    add_px = {sum_r[5] ? 5'h1F : sum_r[4:0],
              sum_g[6] ? 6'h3F : sum_g[5:0],
              sum_b[5] ? 5'h1F : sum_b[4:0]};
    avg_sum = 17'(mod_dest_q & half_mask_i) + 17'(mod_color_q & half_mask_i);

    res_d = '0;
    if (!mod_draw_q) begin
      res_d = '0;
    end else if (mod_skip_q) begin
      res_d.out_pixel    = mod_dest_q;
      res_d.write_enable = 1'b0;
    end else begin
      res_d.write_enable = 1'b1;
      case (blend_mode_e'(mod_mode_q))
        MODE_ADD: begin
          res_d.out_pixel = add_px;
        end
        MODE_AVG: begin
          res_d.out_pixel = avg_sum[16:1];
        end
        default: begin
          res_d.out_pixel = mod_color_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= mod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = res_valid_q;
  assign result_o = res_q;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the RGB565 sprite pixel blender.
// Depends on rspb_pkg and rgb565_sprite_pixel_blend_top; includes its own pixel predictor.
`timescale 1ns / 1ps

module tb_top;
  import rspb_pkg::*;

  localparam logic       ACT_DRAW    = 1'b0;
  localparam logic       ACT_PALETTE = 1'b1;
  // Mode code left unused by the block; it must behave as an opaque write
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  // Drain margin after the last result; the block has 3 register stages
  localparam int         DRAIN_CYCLES = 8;

  typedef struct packed {
    rspb_in_t  item;
    logic      typed;
    rspb_out_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  rspb_in_t    item_i;
  logic        done_o;
  rspb_out_t   result_o;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  // Expected value typed into the stimulus table travels with the transaction
  logic        row_typed;
  rspb_out_t   row_want;

  // Predictor state: register copies and palette mirror
  logic [15:0] tint_color;
  logic [15:0] avg_mask;
  logic [15:0] palette_mirror [PAL_DEPTH];

  // Stimulus side bookkeeping: palette entries that have been written
  bit          slot_filled [PAL_DEPTH];
  int          filled_slots [$];

  rspb_out_t   pixel_q [$];
  stim_row_t   stim_table [$];

  int          mismatch_count;
  int          checked_count;
  int          draw_count;
  int          palette_count;
  int          skip_count;
  int          reg_write_count;
  int          cycle_count;

  rgb565_sprite_pixel_blend_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // Pixel predictor
  // ------------------------------------------------------------------

  // Multiply each channel by the tint channel and drop the fraction bits
  function automatic logic [15:0] tint_565(input logic [15:0] c, input logic [15:0] m);
    logic [9:0]  pr;
    logic [11:0] pg;
    logic [9:0]  pb;
    pr = 10'(c[15:11]) * 10'(m[15:11]);
    pg = 12'(c[10:5]) * 12'(m[10:5]);
    pb = 10'(c[4:0]) * 10'(m[4:0]);
    return {pr[9:5], pg[11:6], pb[9:5]};
  endfunction

  // Per-channel add, clamped at full scale
  function automatic logic [15:0] add_clamp_565(input logic [15:0] d, input logic [15:0] s);
    logic [5:0] sr;
    logic [6:0] sg;
    logic [5:0] sb;
    sr = 6'(d[15:11]) + 6'(s[15:11]);
    sg = 7'(d[10:5]) + 7'(s[10:5]);
    sb = 6'(d[4:0]) + 6'(s[4:0]);
    return {(sr > 6'd31) ? 5'd31 : sr[4:0],
            (sg > 7'd63) ? 6'd63 : sg[5:0],
            (sb > 6'd31) ? 5'd31 : sb[4:0]};
  endfunction

  // Masked sum at 17 bits, halved
  function automatic logic [15:0] avg_masked(input logic [15:0] d, input logic [15:0] s,
                                             input logic [15:0] m);
    logic [16:0] sum;
    sum = {1'b0, d & m} + {1'b0, s & m};
    return sum[16:1];
  endfunction

  function automatic rspb_out_t blend_pixel(input rspb_in_t it);
    rspb_out_t   res;
    logic [15:0] raw;
    logic [15:0] color;
    logic [15:0] tinted;
    res = '0;
    if (it.action == ACT_PALETTE) return res;
    raw   = it.indexed ? {8'h00, it.src_value[7:0]} : it.src_value;
    color = it.indexed ? palette_mirror[it.src_value[7:0]] : it.src_value;
    if (it.skip_zero && raw == 16'h0000) begin
      res.out_pixel    = it.dest_pixel;
      res.write_enable = 1'b0;
      return res;
    end
    tinted = tint_565(color, tint_color);
    case (it.blend_mode)
      MODE_ADD: res.out_pixel = add_clamp_565(it.dest_pixel, tinted);
      MODE_AVG: res.out_pixel = avg_masked(it.dest_pixel, tinted, avg_mask);
      default:  res.out_pixel = tinted;
    endcase
    res.write_enable = 1'b1;
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Checking and acceptance, all at the rising edge
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH @%0t %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : monitor
    rspb_out_t want;
    if (rst_ni) begin
      // Compare a returned transaction against the oldest expectation
      if (done_o) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("result with nothing pending", result_o.out_pixel, 16'h0000);
        end else begin
          want = pixel_q.pop_front();
          checked_count++;
          if (result_o.out_pixel !== want.out_pixel)
            report_mismatch("out_pixel", result_o.out_pixel, want.out_pixel);
          if (result_o.write_enable !== want.write_enable)
            report_mismatch("write_enable", {15'd0, result_o.write_enable},
                            {15'd0, want.write_enable});
        end
      end
      // Track register writes in the predictor
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_MODULATE_COLOR: tint_color = cfg_wdata_i;
          REG_HALF_MASK:      avg_mask   = cfg_wdata_i;
          default: ;
        endcase
      end
      // Predict an accepted transaction; predict before the palette update
      if (start && !busy) begin
        want = row_typed ? row_want : blend_pixel(item_i);
        if (item_i.action == ACT_PALETTE) begin
          palette_mirror[item_i.palette_slot] = item_i.palette_color;
          palette_count++;
        end else begin
          draw_count++;
          if (!want.write_enable) skip_count++;
        end
        pixel_q.push_back(want);
      end
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count, pixel_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  function automatic rspb_in_t mk_item(input logic act, input logic [1:0] mode,
                                       input logic skip, input logic idx,
                                       input logic [15:0] src, input logic [15:0] dest,
                                       input logic [7:0] slot, input logic [15:0] pcol);
    rspb_in_t it;
    it.action        = act;
    it.blend_mode    = mode;
    it.skip_zero     = skip;
    it.indexed       = idx;
    it.src_value     = src;
    it.dest_pixel    = dest;
    it.palette_slot  = slot;
    it.palette_color = pcol;
    return it;
  endfunction

  function automatic rspb_out_t mk_result(input logic [15:0] pix, input logic we);
    rspb_out_t r;
    r.out_pixel    = pix;
    r.write_enable = we;
    return r;
  endfunction

  task automatic add_row(input rspb_in_t it, input logic typed, input rspb_out_t want);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  // Random transaction; indexed draws only touch palette entries already written
  function automatic rspb_in_t random_item();
    rspb_in_t it;
    int       pick;
    it.action        = ($urandom_range(0, 99) < 15) ? ACT_PALETTE : ACT_DRAW;
    it.blend_mode    = 2'($urandom_range(0, 3));
    it.skip_zero     = 1'($urandom_range(0, 1));
    it.indexed       = (filled_slots.size() > 0) ? 1'($urandom_range(0, 1)) : 1'b0;
    it.palette_slot  = 8'($urandom_range(0, 255));
    it.palette_color = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (it.indexed) begin
      it.src_value[15:8] = 8'($urandom);
      it.src_value[7:0]  = (pick == 0 && slot_filled[0]) ? 8'h00 :
                           8'(filled_slots[$urandom_range(0, filled_slots.size() - 1)]);
    end else begin
      it.src_value = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
    end
    pick = $urandom_range(0, 9);
    it.dest_pixel = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
    return it;
  endfunction

  // Present one transaction and hold it until the block takes it
  task automatic send_item(input rspb_in_t it, input logic typed, input rspb_out_t want);
    @(negedge clk_i);
    start     <= 1'b1;
    item_i    <= it;
    row_typed <= typed;
    row_want  <= want;
    if (it.action == ACT_PALETTE && !slot_filled[it.palette_slot]) begin
      slot_filled[it.palette_slot] = 1'b1;
      filled_slots.push_back(int'(it.palette_slot));
    end
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start for a short burst, with junk on the payload
  task automatic idle_burst(input int pct);
    int n;
    if ($urandom_range(0, 99) < pct) begin
      n = $urandom_range(1, 5);
      @(negedge clk_i);
      start     <= 1'b0;
      item_i    <= random_item();
      row_typed <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Lower start and wait until every pending result is back
  task automatic drain();
    @(negedge clk_i);
    start     <= 1'b0;
    row_typed <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the pipeline empty
  task automatic program_regs(input logic [15:0] tint, input logic [15:0] mask);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MODULATE_COLOR;
    cfg_wdata_i <= tint;
    @(negedge clk_i);
    cfg_idx_i   <= REG_HALF_MASK;
    cfg_wdata_i <= mask;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    reg_write_count += 2;
  endtask

  task automatic run_phase(input logic [15:0] tint, input logic [15:0] mask,
                           input int count, input bit idling);
    int pct;
    pct = 0;
    program_regs(tint, mask);
    for (int k = 0; k < count; k++) begin
      // Switch idle density every few dozen transactions, including quiet stretches
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       pct = 0;
          1:       pct = 15;
          default: pct = 40;
        endcase
      end
      if (idling) idle_burst(pct);
      send_item(random_item(), 1'b0, '0);
    end
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    item_i          = '0;
    row_typed       = 1'b0;
    row_want        = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_MODULATE_COLOR;
    cfg_wdata_i     = '0;
    tint_color      = MODULATE_RESET;
    avg_mask        = HALF_MASK_RESET;
    mismatch_count  = 0;
    checked_count   = 0;
    draw_count      = 0;
    palette_count   = 0;
    skip_count      = 0;
    reg_write_count = 0;
    cycle_count     = 0;
    foreach (palette_mirror[i]) palette_mirror[i] = 16'h0000;
    foreach (slot_filled[i]) slot_filled[i] = 1'b0;

    // Directed table, run with register reset values. Fields:
    // action, mode, skip, indexed, src, dest, slot, palette color
    // Palette writes always return a zero, non-writing result
    add_row(mk_item(ACT_PALETTE, MODE_OPAQUE, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00,
                    16'hFFFF), 1'b1, mk_result(16'h0000, 1'b0));
    add_row(mk_item(ACT_PALETTE, MODE_OPAQUE, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'hFF,
                    16'h0000), 1'b1, mk_result(16'h0000, 1'b0));
    add_row(mk_item(ACT_PALETTE, MODE_OPAQUE, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'h55,
                    16'hF800), 1'b1, mk_result(16'h0000, 1'b0));
    add_row(mk_item(ACT_PALETTE, MODE_OPAQUE, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'hAA,
                    16'h07E0), 1'b1, mk_result(16'h0000, 1'b0));
    // Zero direct source skipped: destination passes through unwritten
    add_row(mk_item(ACT_DRAW, MODE_OPAQUE, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 8'h00,
                    16'h0000), 1'b1, mk_result(16'hFFFF, 1'b0));
    // Zero index skipped even with the high source bits set
    add_row(mk_item(ACT_DRAW, MODE_ADD, 1'b1, 1'b1, 16'hFF00, 16'h1234, 8'h00,
                    16'h0000), 1'b1, mk_result(16'h1234, 1'b0));
    // Zero source without skip writes black
    add_row(mk_item(ACT_DRAW, MODE_OPAQUE, 1'b0, 1'b0, 16'h0000, 16'hFFFF, 8'h00,
                    16'h0000), 1'b1, mk_result(16'h0000, 1'b1));
    add_row(mk_item(ACT_DRAW, MODE_OPAQUE, 1'b0, 1'b0, 16'hFFFF, 16'h0000, 8'h00,
                    16'h0000), 1'b0, '0);
    // White destination saturates under add
    add_row(mk_item(ACT_DRAW, MODE_ADD, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 8'h00,
                    16'h0000), 1'b1, mk_result(16'hFFFF, 1'b1));
    add_row(mk_item(ACT_DRAW, MODE_ADD, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00,
                    16'h0000), 1'b1, mk_result(16'h0000, 1'b1));
    add_row(mk_item(ACT_DRAW, MODE_AVG, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00,
                    16'h0000), 1'b1, mk_result(16'h0000, 1'b1));
    add_row(mk_item(ACT_DRAW, MODE_AVG, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 8'h00,
                    16'h0000), 1'b0, '0);
    // Unused mode code acts as opaque
    add_row(mk_item(ACT_DRAW, MODE_SPARE, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 8'h00,
                    16'h0000), 1'b0, '0);
    // Entry 255 holds black
    add_row(mk_item(ACT_DRAW, MODE_OPAQUE, 1'b0, 1'b1, 16'h00FF, 16'hFFFF, 8'h00,
                    16'h0000), 1'b1, mk_result(16'h0000, 1'b1));
    // High index bits must be ignored
    add_row(mk_item(ACT_DRAW, MODE_OPAQUE, 1'b0, 1'b1, 16'hAB55, 16'h0000, 8'h00,
                    16'h0000), 1'b0, '0);
    add_row(mk_item(ACT_DRAW, MODE_ADD, 1'b0, 1'b1, 16'h00AA, 16'hF81F, 8'h00,
                    16'h0000), 1'b0, '0);
    add_row(mk_item(ACT_DRAW, MODE_AVG, 1'b0, 1'b1, 16'h0000, 16'hFFFF, 8'h00,
                    16'h0000), 1'b0, '0);
    // Palette write with every other field set; the entry is read right after
    add_row(mk_item(ACT_PALETTE, MODE_SPARE, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'h01,
                    16'h5AA5), 1'b1, mk_result(16'h0000, 1'b0));
    add_row(mk_item(ACT_DRAW, MODE_ADD, 1'b1, 1'b1, 16'h0001, 16'h0841, 8'h00,
                    16'h0000), 1'b0, '0);
    add_row(mk_item(ACT_DRAW, MODE_OPAQUE, 1'b1, 1'b0, 16'h0001, 16'h0000, 8'h00,
                    16'h0000), 1'b0, '0);
    add_row(mk_item(ACT_DRAW, MODE_AVG, 1'b1, 1'b0, 16'h8000, 16'h0001, 8'h00,
                    16'h0000), 1'b0, '0);

    // Hold reset, then release it away from the sampling edge
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_table[i]) begin
      idle_burst(20);
      send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
    end

    // Random phases through several tint and mask settings, reset values first, then extremes
    run_phase(MODULATE_RESET, HALF_MASK_RESET, 150, 1'b1);
    run_phase(16'h0000, 16'hFFFF, 120, 1'b1);
    run_phase(16'hFFFF, 16'h0000, 120, 1'b1);
    run_phase(16'($urandom), 16'($urandom), 180, 1'b1);
    run_phase(16'h8410, 16'hF7DE, 130, 1'b1);
    // Final stretch runs back to back at full rate
    run_phase(16'($urandom), 16'($urandom), 230, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d draws (%0d skipped) and %0d palette writes over %0d register writes",
             draw_count, skip_count, palette_count, reg_write_count);
    $display("Checked %0d results, %0d mismatches, %0d cycles",
             checked_count, mismatch_count, cycle_count);
    if (mismatch_count == 0 && pixel_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
